// File: sv/sync_length_crc16_frame_parser_top_macros.svh
// Assertion macros shared by the frame parser RTL.
// In synthesis builds the macros expand to nothing.
`ifndef SYNC_LENGTH_CRC16_FRAME_PARSER_TOP_MACROS_SVH
`define SYNC_LENGTH_CRC16_FRAME_PARSER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle property, checked out of reset.
`define SLCFP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Antecedent in one cycle, consequent in the next.
`define SLCFP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SLCFP_ASSERT(label, clk, rstn, prop, msg)
`define SLCFP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// File: sv/slcfp_pkg.sv
`default_nettype none

package slcfp_pkg;

    // Result queue between the parser and the output stage
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    localparam int unsigned TDATA_W = 48;

    // Reflected CRC-16 polynomial
    localparam logic [15:0] CRC_POLY = 16'h8408;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_END_MARKER  = 2'd2;
    localparam logic [1:0] CFG_MAX_LEN     = 2'd3;

    // Register reset values
    localparam logic [7:0]  RST_SYNC_FIRST  = 8'd255;
    localparam logic [7:0]  RST_SYNC_SECOND = 8'd90;
    localparam logic [7:0]  RST_END_MARKER  = 8'd51;
    localparam logic [15:0] RST_MAX_LEN     = 16'd4086;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // End-of-frame status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CRC_ERR  = 2'd1;
    localparam logic [1:0] ST_NO_END   = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    typedef enum logic [3:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_ID,
        PH_CLASS,
        PH_LENLO,
        PH_LENHI,
        PH_DATA,
        PH_CRCLO,
        PH_CRCHI,
        PH_END
    } phase_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  message_id;
        logic [7:0]  class_id;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [1:0]  frame_status;
    } res_t;

    // One byte of the reflected CRC, bit by bit
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/slcfp_front.sv
`default_nettype none

module slcfp_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_fire,
    input  wire logic [7:0]         in_byte,
    output logic                    push_valid,
    output slcfp_pkg::res_t         push_item
);

`include "sync_length_crc16_frame_parser_top_macros.svh"

    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [7:0]  end_marker_reg;
    logic [15:0] max_len_reg;

    slcfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  msg_id_reg, msg_id_next;
    logic [7:0]  class_id_reg, class_id_next;
    logic [15:0] frame_len_reg, frame_len_next;
    logic [15:0] pay_cnt_reg, pay_cnt_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] rx_crc_reg, rx_crc_next;

    logic [15:0] crc_upd;
    logic [15:0] len_full;
    logic [15:0] cnt_inc;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= slcfp_pkg::RST_SYNC_FIRST;
            sync_second_reg <= slcfp_pkg::RST_SYNC_SECOND;
            end_marker_reg  <= slcfp_pkg::RST_END_MARKER;
            max_len_reg     <= slcfp_pkg::RST_MAX_LEN;
        end else if (cfg_valid) begin
            case (cfg_index)
                slcfp_pkg::CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data[7:0];
                slcfp_pkg::CFG_SYNC_SECOND: sync_second_reg <= cfg_data[7:0];
                slcfp_pkg::CFG_END_MARKER:  end_marker_reg  <= cfg_data[7:0];
                slcfp_pkg::CFG_MAX_LEN:     max_len_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= slcfp_pkg::PH_HUNT1;
            msg_id_reg    <= '0;
            class_id_reg  <= '0;
            frame_len_reg <= '0;
            pay_cnt_reg   <= '0;
            crc_reg       <= '0;
            rx_crc_reg    <= '0;
        end else begin
            phase_reg     <= phase_next;
            msg_id_reg    <= msg_id_next;
            class_id_reg  <= class_id_next;
            frame_len_reg <= frame_len_next;
            pay_cnt_reg   <= pay_cnt_next;
            crc_reg       <= crc_next;
            rx_crc_reg    <= rx_crc_next;
        end
    end

    // CRC over the running value; the id byte restarts from zero
    assign crc_upd  = slcfp_pkg::crc_byte((phase_reg == slcfp_pkg::PH_ID) ? 16'h0000 : crc_reg,
                                          in_byte);
    assign len_full = {in_byte, frame_len_reg[7:0]};
    assign cnt_inc  = pay_cnt_reg + 16'd1;

    // Next state and result generation
    always_comb begin
        phase_next     = phase_reg;
        msg_id_next    = msg_id_reg;
        class_id_next  = class_id_reg;
        frame_len_next = frame_len_reg;
        pay_cnt_next   = pay_cnt_reg;
        crc_next       = crc_reg;
        rx_crc_next    = rx_crc_reg;

        push_valid             = 1'b0;
        push_item.item_kind    = slcfp_pkg::KIND_STATUS;
        push_item.message_id   = msg_id_reg;
        push_item.class_id     = class_id_reg;
        push_item.payload_byte = 8'h00;
        push_item.byte_index   = frame_len_reg;
        push_item.frame_status = slcfp_pkg::ST_OK;

        if (in_fire) begin
            case (phase_reg)
                slcfp_pkg::PH_HUNT2: begin
                    if (in_byte == sync_second_reg) begin
                        phase_next = slcfp_pkg::PH_ID;
                    end else if (in_byte != sync_first_reg) begin
                        phase_next = slcfp_pkg::PH_HUNT1;
                    end
                end
                slcfp_pkg::PH_ID: begin
                    msg_id_next = in_byte;
                    crc_next    = crc_upd;
                    phase_next  = slcfp_pkg::PH_CLASS;
                end
                slcfp_pkg::PH_CLASS: begin
                    class_id_next = in_byte;
                    crc_next      = crc_upd;
                    phase_next    = slcfp_pkg::PH_LENLO;
                end
                slcfp_pkg::PH_LENLO: begin
                    frame_len_next = {8'h00, in_byte};
                    crc_next       = crc_upd;
                    phase_next     = slcfp_pkg::PH_LENHI;
                end
                slcfp_pkg::PH_LENHI: begin
                    frame_len_next = len_full;
                    crc_next       = crc_upd;
                    pay_cnt_next   = '0;
                    if (len_full > max_len_reg) begin
                        // oversize frame: report and drop back to hunting
                        push_valid             = 1'b1;
                        push_item.byte_index   = len_full;
                        push_item.frame_status = slcfp_pkg::ST_TOO_LONG;
                        phase_next             = slcfp_pkg::PH_HUNT1;
                    end else if (len_full == 16'd0) begin
                        phase_next = slcfp_pkg::PH_CRCLO;
                    end else begin
                        phase_next = slcfp_pkg::PH_DATA;
                    end
                end
                slcfp_pkg::PH_DATA: begin
                    push_valid             = 1'b1;
                    push_item.item_kind    = slcfp_pkg::KIND_PAYLOAD;
                    push_item.payload_byte = in_byte;
                    push_item.byte_index   = pay_cnt_reg;
                    crc_next               = crc_upd;
                    pay_cnt_next           = cnt_inc;
                    if (cnt_inc >= frame_len_reg) begin
                        phase_next = slcfp_pkg::PH_CRCLO;
                    end
                end
                slcfp_pkg::PH_CRCLO: begin
                    rx_crc_next = {8'h00, in_byte};
                    phase_next  = slcfp_pkg::PH_CRCHI;
                end
                slcfp_pkg::PH_CRCHI: begin
                    rx_crc_next = {in_byte, rx_crc_reg[7:0]};
                    phase_next  = slcfp_pkg::PH_END;
                end
                slcfp_pkg::PH_END: begin
                    // a bad end byte outranks a CRC mismatch
                    push_valid = 1'b1;
                    if (in_byte != end_marker_reg) begin
                        push_item.frame_status = slcfp_pkg::ST_NO_END;
                    end else if (rx_crc_reg != crc_reg) begin
                        push_item.frame_status = slcfp_pkg::ST_CRC_ERR;
                    end else begin
                        push_item.frame_status = slcfp_pkg::ST_OK;
                    end
                    phase_next = slcfp_pkg::PH_HUNT1;
                end
                default: begin
                    phase_next = (in_byte == sync_first_reg) ? slcfp_pkg::PH_HUNT2
                                                             : slcfp_pkg::PH_HUNT1;
                end
            endcase
        end
    end

    // Results only come from payload, length-high and end phases
    `SLCFP_ASSERT(a_push_phase, aclk, aresetn, !push_valid || (in_fire && (phase_reg == slcfp_pkg::PH_DATA || phase_reg == slcfp_pkg::PH_LENHI || phase_reg == slcfp_pkg::PH_END)), "result pushed outside a result phase")
    // A completed frame always returns to hunting
    `SLCFP_ASSERT_NEXT(a_end_hunt, aclk, aresetn, in_fire && phase_reg == slcfp_pkg::PH_END, phase_reg == slcfp_pkg::PH_HUNT1, "parser did not return to hunting after end byte")

endmodule

`default_nettype wire

// File: sv/slcfp_queue.sv
`default_nettype none

module slcfp_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire slcfp_pkg::res_t    push_item,
    input  wire logic               pop,
    output logic                    full,
    output logic                    empty,
    output slcfp_pkg::res_t         head_item
);

`include "sync_length_crc16_frame_parser_top_macros.svh"

    localparam int unsigned QAW = slcfp_pkg::QAW;
    localparam int unsigned QCW = slcfp_pkg::QCW;

    slcfp_pkg::res_t mem [slcfp_pkg::QDEPTH];

    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(slcfp_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(slcfp_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    assign full      = (count_reg == QCW'(slcfp_pkg::QDEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = mem[rd_ptr_reg];

    `SLCFP_ASSERT(a_q_bound, aclk, aresetn, count_reg <= QCW'(slcfp_pkg::QDEPTH), "queue count over depth")
    `SLCFP_ASSERT(a_q_push_full, aclk, aresetn, !(push && full), "push into full queue")
    `SLCFP_ASSERT(a_q_pop_empty, aclk, aresetn, !(pop && empty), "pop from empty queue")

endmodule

`default_nettype wire

// File: sv/slcfp_back.sv
`default_nettype none

module slcfp_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire slcfp_pkg::res_t                   head_item,
    input  wire logic                              q_empty,
    output logic                                   pop,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [slcfp_pkg::TDATA_W-1:0]          m_tdata,
    output logic                                   m_tuser
);

    logic            out_valid_reg, out_valid_next;
    slcfp_pkg::res_t out_item_reg;

    // Load the output register whenever it is empty or being taken
    assign pop            = !q_empty && (!out_valid_reg || m_tready);
    assign out_valid_next = pop || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_item_reg <= head_item;
        end
    end

    // Pack the result item onto the stream
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_item_reg.item_kind;
    assign m_tdata  = {6'b000000,
                       out_item_reg.frame_status,
                       out_item_reg.byte_index,
                       out_item_reg.payload_byte,
                       out_item_reg.class_id,
                       out_item_reg.message_id};

endmodule

`default_nettype wire

// File: sv/sync_length_crc16_frame_parser_top.sv
// A result passes through the result queue and then the output register before it can be taken on m_.
// Throughput: one byte per cycle; the byte parser and CRC-16 update are combinational.
// Input stalls only when the four-entry result queue is full under output back-pressure.
// Reset: synchronous, active low; registers go to their defaults, parser hunts for sync.
// No clearing pass: the block takes bytes in the first cycle after reset.
`default_nettype none

module sync_length_crc16_frame_parser_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [7:0] rx_byte
    // result items
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [7:0] message_id, [15:8] class_id, [23:16] payload_byte,
    // [39:24] byte_index, [41:40] frame_status, [47:42] zero
    output logic [slcfp_pkg::TDATA_W-1:0]          m_tdata,
    output logic                                   m_tuser,   // [0] item_kind
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [15:0]                       cfg_data
);

    logic            in_fire;
    logic            push_valid;
    slcfp_pkg::res_t push_item;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    slcfp_pkg::res_t head_item;

    assign s_tready  = !q_full;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Front: byte parser and CRC
    slcfp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_fire    (in_fire),
        .in_byte    (s_tdata),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    // Result queue
    slcfp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head_item (head_item)
    );

    // Back: output register
    slcfp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_item (head_item),
        .q_empty   (q_empty),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import slcfp_pkg::*;

    localparam int STUCK_LIMIT     = 4000;
    localparam int NUM_PHASES      = 8;
    localparam int BYTES_PER_PHASE = 212;

    // Predicts the deframer output and holds the results still owed by the block
    class deframe_checker;
        logic [7:0]  sync_a;
        logic [7:0]  sync_b;
        logic [7:0]  end_byte;
        logic [15:0] len_limit;

        phase_t      phase;
        logic [7:0]  msg_id;
        logic [7:0]  cls_id;
        logic [15:0] length;
        logic [15:0] pay_count;
        logic [15:0] crc_acc;
        logic [15:0] crc_got;

        res_t        pending_results[$];
        int          errors;
        int          seen;

        function new();
            sync_a    = RST_SYNC_FIRST;
            sync_b    = RST_SYNC_SECOND;
            end_byte  = RST_END_MARKER;
            len_limit = RST_MAX_LEN;
            phase     = PH_HUNT1;
            msg_id    = '0;
            cls_id    = '0;
            length    = '0;
            pay_count = '0;
            crc_acc   = '0;
            crc_got   = '0;
            errors    = 0;
            seen      = 0;
        endfunction

        // Reflected CRC-16, one input bit at a time, LSB first
        static function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
            logic fb;
            for (int i = 0; i < 8; i++) begin
                fb  = crc[0] ^ b[i];
                crc = crc >> 1;
                if (fb) crc = crc ^ CRC_POLY;
            end
            return crc;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_SYNC_FIRST:  sync_a    = val[7:0];
                CFG_SYNC_SECOND: sync_b    = val[7:0];
                CFG_END_MARKER:  end_byte  = val[7:0];
                CFG_MAX_LEN:     len_limit = val;
                default: ;
            endcase
        endfunction

        function void owe(logic kind, logic [7:0] data, logic [15:0] idx, logic [1:0] st);
            res_t r;
            r.item_kind    = kind;
            r.message_id   = msg_id;
            r.class_id     = cls_id;
            r.payload_byte = data;
            r.byte_index   = idx;
            r.frame_status = st;
            pending_results.push_back(r);
        endfunction

        // Advance the parser by one accepted byte
        function void take_byte(logic [7:0] b);
            case (phase)
                PH_HUNT2: begin
                    if (b == sync_b) phase = PH_ID;
                    else if (b != sync_a) phase = PH_HUNT1;
                end
                PH_ID: begin
                    msg_id  = b;
                    crc_acc = crc_update(16'h0000, b);
                    phase   = PH_CLASS;
                end
                PH_CLASS: begin
                    cls_id  = b;
                    crc_acc = crc_update(crc_acc, b);
                    phase   = PH_LENLO;
                end
                PH_LENLO: begin
                    length  = {8'h00, b};
                    crc_acc = crc_update(crc_acc, b);
                    phase   = PH_LENHI;
                end
                PH_LENHI: begin
                    length    = {b, length[7:0]};
                    crc_acc   = crc_update(crc_acc, b);
                    pay_count = '0;
                    if (length > len_limit) begin
                        owe(KIND_STATUS, 8'h00, length, ST_TOO_LONG);
                        phase = PH_HUNT1;
                    end else begin
                        phase = (length == 16'd0) ? PH_CRCLO : PH_DATA;
                    end
                end
                PH_DATA: begin
                    owe(KIND_PAYLOAD, b, pay_count, ST_OK);
                    crc_acc   = crc_update(crc_acc, b);
                    pay_count = pay_count + 16'd1;
                    if (pay_count >= length) phase = PH_CRCLO;
                end
                PH_CRCLO: begin
                    crc_got = {8'h00, b};
                    phase   = PH_CRCHI;
                end
                PH_CRCHI: begin
                    crc_got = {b, crc_got[7:0]};
                    phase   = PH_END;
                end
                PH_END: begin
                    // a bad end byte outranks a bad CRC
                    if (b != end_byte)        owe(KIND_STATUS, 8'h00, length, ST_NO_END);
                    else if (crc_got != crc_acc) owe(KIND_STATUS, 8'h00, length, ST_CRC_ERR);
                    else                      owe(KIND_STATUS, 8'h00, length, ST_OK);
                    phase = PH_HUNT1;
                end
                default: phase = (b == sync_a) ? PH_HUNT2 : PH_HUNT1;
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Compare one accepted result with the oldest owed one
        task check_result(logic kind, logic [TDATA_W-1:0] data);
            res_t want;
            seen++;
            if (pending_results.size() == 0) begin
                report($sformatf("result %0d unexpected: kind %0d data %h", seen, kind, data));
                return;
            end
            want = pending_results.pop_front();
            if (kind !== want.item_kind)
                report($sformatf("result %0d kind %0d, want %0d", seen, kind, want.item_kind));
            if (data[7:0] !== want.message_id)
                report($sformatf("result %0d message_id %h, want %h",
                                 seen, data[7:0], want.message_id));
            if (data[15:8] !== want.class_id)
                report($sformatf("result %0d class_id %h, want %h",
                                 seen, data[15:8], want.class_id));
            if (data[23:16] !== want.payload_byte)
                report($sformatf("result %0d payload_byte %h, want %h",
                                 seen, data[23:16], want.payload_byte));
            if (data[39:24] !== want.byte_index)
                report($sformatf("result %0d byte_index %0d, want %0d",
                                 seen, data[39:24], want.byte_index));
            if (data[41:40] !== want.frame_status)
                report($sformatf("result %0d frame_status %0d, want %0d",
                                 seen, data[41:40], want.frame_status));
        endtask
    endclass

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = 8'h00;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = CFG_SYNC_FIRST;
    logic [15:0]         cfg_data  = 16'h0000;

    deframe_checker sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int phase_bytes    = 0;
    int stuck_cycles   = 0;

    sync_length_crc16_frame_parser_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Bytes in feed the predictor first, then results out are checked
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.take_byte(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
        end
    end

    // Watchdog: cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken
    task automatic push_byte(input logic [7:0] b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        phase_bytes++;
        @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
    endtask

    // Stop sending and let every owed result drain
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Full frame, or only its first cut bytes when cut >= 0
    task automatic send_frame(input logic [7:0] id, input logic [7:0] cls, input int len,
                              input bit bad_crc, input logic [7:0] endb, input int cut);
        logic [7:0]  frame_q[$];
        logic [15:0] crc;
        logic [15:0] len16;
        logic [7:0]  b;
        int          n;
        len16   = len[15:0];
        frame_q = {sb.sync_a, sb.sync_b, id, cls, len16[7:0], len16[15:8]};
        crc     = 16'h0000;
        for (int i = 2; i < 6; i++) crc = deframe_checker::crc_update(crc, frame_q[i]);
        if (cut < 0) begin
            for (int i = 0; i < len; i++) begin
                b   = 8'($urandom_range(255));
                crc = deframe_checker::crc_update(crc, b);
                frame_q.push_back(b);
            end
            if (bad_crc) crc = crc ^ 16'($urandom_range(65535, 1));
            frame_q.push_back(crc[7:0]);
            frame_q.push_back(crc[15:8]);
            frame_q.push_back(endb);
        end
        n = (cut < 0) ? frame_q.size() : cut;
        for (int i = 0; i < n; i++) push_byte(frame_q[i]);
    endtask

    // Mostly short payloads, a few longer, sometimes exactly at the limit
    function automatic int pick_length();
        int r;
        int len;
        int cap;
        cap = sb.len_limit;
        r   = $urandom_range(99);
        if (r < 80)      len = $urandom_range(8);
        else if (r < 98) len = $urandom_range(40, 9);
        else             len = $urandom_range(300, 41);
        if (len > cap) len = $urandom_range(cap);
        if (cap <= 300 && $urandom_range(9) == 0) len = cap;
        return len;
    endfunction

    task automatic send_random_unit();
        int         pick;
        int         len;
        int         lim;
        logic [7:0] endb;
        pick = $urandom_range(99);
        len  = pick_length();
        lim  = sb.len_limit;
        if (pick < 58) begin
            send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len, 1'b0,
                       sb.end_byte, -1);
        end else if (pick < 70) begin
            send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len, 1'b1,
                       sb.end_byte, -1);
        end else if (pick < 78) begin
            // wrong end byte, often equal to the first sync byte
            endb = $urandom_range(1) ? sb.sync_a : 8'($urandom_range(255));
            if (endb == sb.end_byte) endb = ~endb;
            send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len,
                       1'($urandom_range(1)), endb, -1);
        end else if (pick < 88 && lim < 65535) begin
            // length over the limit: header only
            if ($urandom_range(2) == 0)      len = lim + 1;
            else if ($urandom_range(3) == 0) len = 65535;
            else                             len = lim + 1 + $urandom_range(65534 - lim);
            send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len, 1'b0,
                       sb.end_byte, 6);
        end else if (pick < 94) begin
            // broken header
            send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len, 1'b0,
                       sb.end_byte, $urandom_range(5, 1));
        end else begin
            repeat ($urandom_range(6, 1))
                push_byte(($urandom_range(3) == 0) ? sb.sync_a : 8'($urandom_range(255)));
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase

            if (p > 0) begin
                wait_quiet();
                case (p)
                    1: begin
                        cfg_write(CFG_SYNC_FIRST, 16'h0000);
                        cfg_write(CFG_SYNC_SECOND, 16'h00FF);
                        cfg_write(CFG_END_MARKER, 16'h0000);
                        cfg_write(CFG_MAX_LEN, 16'h0000);
                    end
                    2: begin
                        // both sync bytes equal
                        cfg_write(CFG_SYNC_FIRST, 16'h00FF);
                        cfg_write(CFG_SYNC_SECOND, 16'h00FF);
                        cfg_write(CFG_END_MARKER, 16'h00FF);
                        cfg_write(CFG_MAX_LEN, 16'hFFFF);
                    end
                    3: begin
                        cfg_write(CFG_SYNC_FIRST, 16'($urandom_range(255)));
                        cfg_write(CFG_SYNC_SECOND, 16'($urandom_range(255)));
                        cfg_write(CFG_END_MARKER, 16'($urandom_range(255)));
                        cfg_write(CFG_MAX_LEN, 16'd3);
                    end
                    default: begin
                        cfg_write(CFG_SYNC_FIRST, 16'($urandom_range(255)));
                        cfg_write(CFG_SYNC_SECOND, 16'($urandom_range(255)));
                        cfg_write(CFG_END_MARKER, 16'($urandom_range(255)));
                        cfg_write(CFG_MAX_LEN, ($urandom_range(3) == 0) ?
                                  16'($urandom_range(65535)) : 16'($urandom_range(40)));
                    end
                endcase
                cfg_valid <= 1'b0;
            end else begin
                // sync hunt: repeated first sync byte waits, other byte drops back
                push_byte(8'hFF);
                push_byte(8'hFF);
                push_byte(8'h12);
                // empty payload, good frame
                send_frame(8'hFF, 8'h00, 0, 1'b0, sb.end_byte, -1);
                // largest length field, over the limit
                send_frame(8'h00, 8'hFF, 65535, 1'b0, sb.end_byte, 6);
                // bad CRC and bad end byte together; end byte looks like a sync byte
                send_frame(8'hA5, 8'h5A, 1, 1'b1, sb.sync_a, -1);
                push_byte(sb.sync_b);
            end

            phase_bytes = 0;
            while (phase_bytes < BYTES_PER_PHASE) send_random_unit();
        end

        wait_quiet();
        repeat (8) @(negedge aclk);
        if (sb.pending() != 0) sb.report("results still owed at end of run");
        if (sb.errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
